>>> sv/rdsc_pkg.sv
`default_nettype none
package rdsc_pkg;

   // Fixed field widths
   localparam int VALUE_W = 64;
   localparam int CHAR_W = 8;
   localparam int DIGIT_W = 4;
   localparam int BASE_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // Divider works this many dividend bits per cycle
   localparam int STEP_BITS = 8;
   localparam int DIV_STEPS = VALUE_W / STEP_BITS;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   // Defaults for top level parameters
   localparam int DEF_MAX_DIGITS = 64;
   localparam int DEF_MAX_BASE = 16;

   // Register indexes
   localparam logic [1:0] REG_BASE_LENGTH = 2'd0;
   localparam logic [1:0] REG_CHARS_LOW = 2'd1;
   localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

   // Register reset values
   localparam logic [BASE_W-1:0] RST_BASE_LENGTH = 5'd16;
   localparam logic [CSR_DATA_W-1:0] RST_CHARS_LOW = 64'h3736353433323130;
   localparam logic [CSR_DATA_W-1:0] RST_CHARS_HIGH = 64'h6665646362613938;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Map a digit to its character from the two table registers
   function automatic logic [CHAR_W-1:0] char_of_digit(
      input logic [DIGIT_W-1:0] digit,
      input logic [CSR_DATA_W-1:0] chars_low,
      input logic [CSR_DATA_W-1:0] chars_high
   );
      logic [CSR_DATA_W-1:0] row;
      row = digit[3] ? chars_high : chars_low;
      return row[digit[2:0]*CHAR_W +: CHAR_W];
   endfunction

endpackage
`default_nettype wire

>>> sv/rdsc_req_if.sv
`default_nettype none
interface rdsc_req_if import rdsc_pkg::*; ();
   logic valid;
   logic ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

>>> sv/rdsc_rsp_if.sv
`default_nettype none
interface rdsc_rsp_if import rdsc_pkg::*; ();
   logic valid;
   logic ready;
   logic [CHAR_W-1:0] digit_char;
   logic last;
   logic error;

   modport source (output valid, output digit_char, output last, output error, input ready);
   modport sink (input valid, input digit_char, input last, input error, output ready);
endinterface
`default_nettype wire

>>> sv/rdsc_div_unit.sv
`default_nettype none
// Restoring divider of a 64-bit value by a small base, STEP_BITS quotient bits a cycle.
module rdsc_div_unit import rdsc_pkg::*; #(
   parameter int MAX_BASE = DEF_MAX_BASE,
   localparam int REM_W = $clog2(MAX_BASE) + 1
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [VALUE_W-1:0] dividend,
   input wire logic [REM_W-1:0] base,
   output div_status_type status,
   output logic [VALUE_W-1:0] quotient,
   output logic [REM_W-1:0] remainder
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0] q_ff, q_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] q_step;
   logic [REM_W-1:0] r_step;

   // One slice of long division: shift in a dividend bit, subtract base when it fits
   always_comb begin
      q_step = q_ff;
      r_step = rem_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         r_step = {r_step[REM_W-2:0], q_step[VALUE_W-1]};
         q_step = {q_step[VALUE_W-2:0], 1'b0};
         if (r_step >= base) begin
            r_step = r_step - base;
            q_step[0] = 1'b1;
         end
      end
   end

   // Sequence the slices
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         q_in = dividend;
         rem_in = '0;
      end else if (busy_ff) begin
         q_in = q_step;
         rem_in = r_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = q_ff;
   assign remainder = rem_ff;

   // Done only follows a busy cycle
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   // Remainder stays below the base once finished
   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      done_ff && !$past(start) |-> rem_ff < base) else $error("remainder not below base");
   // Never busy and done together
   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff)) else $error("divider busy and done together");

endmodule
`default_nettype wire

>>> sv/radix_digit_string_converter.sv
`default_nettype none
// Converts one unsigned 64-bit word into its digit characters in base 2..16 (bases above
// MAX_BASE saturate), most significant first, last set on the final character. A base
// below 2 gives one word with character 0, last and error set. Digits come from a shared
// divider that handles 8 dividend bits per cycle. Each digit is one divider run: its
// remainder is stored and the divider restarts on the quotient until that is zero or
// the store is full. The characters then leave one per cycle, while the output is not
// stalled, from the digit memory, which has a registered read (up to 16 digits in base
// 16, up to 64 in base 2). The input is ready only while the block is idle. Registers
// sit on the APB port at byte addresses 0 (base_length), 8 (digit_chars_low) and 16
// (digit_chars_high), 64-bit data.
module radix_digit_string_converter import rdsc_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int MAX_BASE = DEF_MAX_BASE
) (
   input wire logic clock,
   input wire logic reset,
   rdsc_req_if.sink req_chan,
   rdsc_rsp_if.source rsp_chan,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int REM_W = $clog2(MAX_BASE) + 1;
   localparam int AW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;
   localparam logic [1:0] S_ERR = 2'd3;

   // Configuration registers
   logic [BASE_W-1:0] base_length_ff;
   logic [CSR_DATA_W-1:0] chars_low_ff, chars_high_ff;
   logic csr_write;
   logic [1:0] csr_index;

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= RST_BASE_LENGTH;
         chars_low_ff <= RST_CHARS_LOW;
         chars_high_ff <= RST_CHARS_HIGH;
      end else if (csr_write) begin
         case (csr_index)
            REG_BASE_LENGTH: base_length_ff <= csr_pwdata[BASE_W-1:0];
            REG_CHARS_LOW: chars_low_ff <= csr_pwdata;
            REG_CHARS_HIGH: chars_high_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BASE_LENGTH: csr_prdata = CSR_DATA_W'(base_length_ff);
         REG_CHARS_LOW: csr_prdata = chars_low_ff;
         REG_CHARS_HIGH: csr_prdata = chars_high_ff;
         default: csr_prdata = '0;
      endcase
   end

   // Saturate base to what the divider handles
   logic [REM_W-1:0] base_sat;
   logic base_bad;
   assign base_sat = (base_length_ff > BASE_W'(MAX_BASE)) ? REM_W'(MAX_BASE)
                                                          : REM_W'(base_length_ff);
   assign base_bad = base_length_ff < BASE_W'(2);

   // Sequencer registers
   logic [1:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [CW-1:0] rd_left_ff, rd_left_in;
   logic [CW-1:0] out_left_ff, out_left_in;
   logic rd_valid_ff, rd_valid_in;
   logic [DIGIT_W-1:0] rd_data_ff;
   logic out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic out_last_ff, out_last_in;
   logic out_error_ff, out_error_in;

   // Divider hookup
   logic div_start;
   logic [VALUE_W-1:0] div_dividend;
   div_status_type div_status;
   logic [VALUE_W-1:0] div_quotient;
   logic [REM_W-1:0] div_remainder;

   rdsc_div_unit #(.MAX_BASE(MAX_BASE)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dividend),
      .base(base_sat),
      .status(div_status),
      .quotient(div_quotient),
      .remainder(div_remainder)
   );

   // Digit memory, least significant digit first
   logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
   logic mem_wr;
   logic mem_rd;

   always_ff @(posedge clock) begin
      if (mem_wr)
         digit_store[count_ff[AW-1:0]] <= DIGIT_W'(div_remainder);
      if (mem_rd)
         rd_data_ff <= digit_store[rd_addr_ff];
   end

   logic accept;
   logic out_free;
   logic load_emit, load_err;
   logic [CW-1:0] count_next;
   logic div_finish;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign load_emit = (state_ff == S_EMIT) && rd_valid_ff && out_free;
   assign load_err = (state_ff == S_ERR) && out_free;
   assign count_next = count_ff + 1'b1;
   assign mem_wr = (state_ff == S_DIV) && div_status.done;
   assign div_finish = (div_quotient == '0) || (count_next == CW'(MAX_DIGITS));
   assign mem_rd = (state_ff == S_EMIT) && (rd_left_ff != '0) && (!rd_valid_ff || load_emit);
   assign div_start = (accept && !base_bad) || (mem_wr && !div_finish);
   assign div_dividend = (state_ff == S_IDLE) ? req_chan.value : div_quotient;

   // Next state and datapath control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_addr_in = rd_addr_ff;
      rd_left_in = rd_left_ff;
      out_left_in = out_left_ff;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      out_error_in = out_error_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in = '0;
               state_in = base_bad ? S_ERR : S_DIV;
            end
         end
         S_DIV: begin
            // keep each remainder, stop on zero quotient or full store
            if (mem_wr) begin
               count_in = count_next;
               if (div_finish) begin
                  state_in = S_EMIT;
                  rd_addr_in = count_ff[AW-1:0];
                  rd_left_in = count_next;
                  out_left_in = count_next;
               end
            end
         end
         S_EMIT: begin
            if (mem_rd) begin
               rd_addr_in = rd_addr_ff - 1'b1;
               rd_left_in = rd_left_ff - 1'b1;
            end
            if (load_emit) begin
               out_char_in = char_of_digit(rd_data_ff, chars_low_ff, chars_high_ff);
               out_last_in = (out_left_ff == CW'(1));
               out_error_in = 1'b0;
               out_left_in = out_left_ff - 1'b1;
               if (out_left_ff == CW'(1))
                  state_in = S_IDLE;
            end
         end
         S_ERR: begin
            if (load_err) begin
               out_char_in = '0;
               out_last_in = 1'b1;
               out_error_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output word holds until taken
   always_comb begin
      if (load_emit || load_err)
         out_valid_in = 1'b1;
      else if (rsp_chan.ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   assign rd_valid_in = mem_rd || (rd_valid_ff && !load_emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rd_left_ff <= '0;
         out_left_ff <= '0;
         rd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_left_ff <= rd_left_in;
         out_left_ff <= out_left_in;
         rd_valid_ff <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
      rd_addr_ff <= rd_addr_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_error_ff <= out_error_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.digit_char = out_char_ff;
   assign rsp_chan.last = out_last_ff;
   assign rsp_chan.error = out_error_ff;

   // Error word is a lone zero character with last set
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error |-> rsp_chan.last && rsp_chan.digit_char == '0)
      else $error("malformed error word");
   // Digit count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DIGITS)) else $error("digit count overflow");
   // No pending memory read outside the emit phase
   a_rd_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_EMIT |-> !rd_valid_ff) else $error("stray digit read");
   // A bad base sends the item straight to the error word
   a_bad_base: assert property (@(posedge clock) disable iff (reset)
      accept && base_bad |=> state_ff == S_ERR) else $error("bad base not flagged");
   // Divider runs only while converting
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == S_DIV) else $error("divider busy outside divide phase");

endmodule
`default_nettype wire
